>>> rtl/core/chip8x_pkg.sv
package chip8x_pkg;

  // Widths of the architectural state.
  localparam int unsigned AddrW = 12;
  localparam int unsigned RegW  = 8;
  localparam int unsigned RegNumW = 4;

  // Default depth of the return stack.
  localparam int unsigned StackDepthDefault = 16;

  // Program counter value after reset.
  localparam logic [AddrW-1:0] EntryReset = 12'h200;

  // Fixed opcodes of the system group and low bytes of the key group.
  localparam logic [15:0] OpCls  = 16'h00E0;
  localparam logic [15:0] OpRet  = 16'h00EE;
  localparam logic [7:0]  KkSkp  = 8'h9E;
  localparam logic [7:0]  KkSknp = 8'hA1;

  // Instruction group from the top nibble of the opcode.
  typedef enum logic [3:0] {
    GRP_SYS     = 4'h0,
    GRP_JP      = 4'h1,
    GRP_CALL    = 4'h2,
    GRP_SE_IMM  = 4'h3,
    GRP_SNE_IMM = 4'h4,
    GRP_SE_REG  = 4'h5,
    GRP_LD_IMM  = 4'h6,
    GRP_ADD_IMM = 4'h7,
    GRP_ALU     = 4'h8,
    GRP_SNE_REG = 4'h9,
    GRP_LD_I    = 4'hA,
    GRP_JP_V0   = 4'hB,
    GRP_RND     = 4'hC,
    GRP_DRW     = 4'hD,
    GRP_KEY     = 4'hE,
    GRP_MISC    = 4'hF
  } op_group_e;

  // Register-register operations selected by the low nibble of 8xyN.
  typedef enum logic [3:0] {
    ALU_MOV  = 4'h0,
    ALU_OR   = 4'h1,
    ALU_AND  = 4'h2,
    ALU_XOR  = 4'h3,
    ALU_ADD  = 4'h4,
    ALU_SUB  = 4'h5,
    ALU_SHR  = 4'h6,
    ALU_SUBN = 4'h7,
    ALU_SHL  = 4'hE
  } alu_op_e;

  // Everything one instruction reports.
  typedef struct packed {
    logic [AddrW-1:0]   next_pc;
    logic [AddrW-1:0]   index_value;
    logic               reg_written;
    logic [RegNumW-1:0] reg_number;
    logic [RegW-1:0]    reg_value;
    logic               flag_written;
    logic               flag_value;
    logic               clear_screen;
    logic               skipped;
    logic               stack_fault;
    logic               unsupported;
  } result_t;

  // Return stack control from the execute unit.
  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctrl_t;

endpackage

>>> rtl/core/chip8x_exec.sv
module chip8x_exec (
  input  logic [15:0]                       opcode_i,
  input  logic [15:0]                       key_states_i,
  input  logic [7:0]                        random_byte_i,
  input  logic [chip8x_pkg::RegW-1:0]       vx_i,
  input  logic [chip8x_pkg::RegW-1:0]       vy_i,
  input  logic [chip8x_pkg::RegW-1:0]       v0_i,
  input  logic [chip8x_pkg::AddrW-1:0]      pc_i,
  input  logic [chip8x_pkg::AddrW-1:0]      index_i,
  input  logic [chip8x_pkg::AddrW-1:0]      stack_top_i,
  input  logic                              stack_empty_i,
  input  logic                              stack_full_i,
  output chip8x_pkg::result_t               result_o,
  output chip8x_pkg::stack_ctrl_t           stack_ctrl_o
);

  logic [3:0]                     x;
  logic [3:0]                     n;
  logic [7:0]                     kk;
  logic [chip8x_pkg::AddrW-1:0]   nnn;
  logic [chip8x_pkg::AddrW-1:0]   pc_plus2;
  logic [chip8x_pkg::AddrW-1:0]   pc_plus4;
  logic [chip8x_pkg::RegW:0]      sum_xy;
  logic                           is_skip;
  logic                           cond;
  logic                           key_down;

  assign x        = opcode_i[11:8];
  assign n        = opcode_i[3:0];
  assign kk       = opcode_i[7:0];
  assign nnn      = opcode_i[11:0];
  assign pc_plus2 = pc_i + 12'd2;
  assign pc_plus4 = pc_i + 12'd4;
  assign sum_xy   = {1'b0, vx_i} + {1'b0, vy_i};
  assign key_down = key_states_i[vx_i[3:0]];

  // Decode and execute one instruction.
  always_comb begin
    result_o              = '0;
    result_o.next_pc      = pc_plus2;
    result_o.index_value  = index_i;
    stack_ctrl_o          = '0;
    is_skip               = 1'b0;
    cond                  = 1'b0;

    case (chip8x_pkg::op_group_e'(opcode_i[15:12]))
      chip8x_pkg::GRP_SYS: begin
        if (opcode_i == chip8x_pkg::OpCls) begin
          result_o.clear_screen = 1'b1;
        end else if (opcode_i == chip8x_pkg::OpRet) begin
          if (stack_empty_i) begin
            result_o.stack_fault = 1'b1;
          end else begin
            stack_ctrl_o.pop = 1'b1;
            result_o.next_pc = stack_top_i + 12'd2;
          end
        end else begin
          result_o.unsupported = 1'b1;
        end
      end
      chip8x_pkg::GRP_JP: begin
        result_o.next_pc = nnn;
      end
      chip8x_pkg::GRP_CALL: begin
        if (stack_full_i) begin
          result_o.stack_fault = 1'b1;
        end else begin
          stack_ctrl_o.push = 1'b1;
          result_o.next_pc  = nnn;
        end
      end
      chip8x_pkg::GRP_SE_IMM: begin
        is_skip = 1'b1;
        cond    = (vx_i == kk);
      end
      chip8x_pkg::GRP_SNE_IMM: begin
        is_skip = 1'b1;
        cond    = (vx_i != kk);
      end
      chip8x_pkg::GRP_SE_REG: begin
        if (n == 4'h0) begin
          is_skip = 1'b1;
          cond    = (vx_i == vy_i);
        end else begin
          result_o.unsupported = 1'b1;
        end
      end
      chip8x_pkg::GRP_LD_IMM: begin
        result_o.reg_written = 1'b1;
        result_o.reg_number  = x;
        result_o.reg_value   = kk;
      end
      chip8x_pkg::GRP_ADD_IMM: begin
        result_o.reg_written = 1'b1;
        result_o.reg_number  = x;
        result_o.reg_value   = vx_i + kk;
      end
      chip8x_pkg::GRP_ALU: begin
        result_o.reg_written = 1'b1;
        result_o.reg_number  = x;
        case (chip8x_pkg::alu_op_e'(n))
          chip8x_pkg::ALU_MOV: result_o.reg_value = vy_i;
          chip8x_pkg::ALU_OR:  result_o.reg_value = vx_i | vy_i;
          chip8x_pkg::ALU_AND: result_o.reg_value = vx_i & vy_i;
          chip8x_pkg::ALU_XOR: result_o.reg_value = vx_i ^ vy_i;
          chip8x_pkg::ALU_ADD: begin
            result_o.flag_written = 1'b1;
            result_o.flag_value   = sum_xy[chip8x_pkg::RegW];
            result_o.reg_value    = sum_xy[chip8x_pkg::RegW-1:0];
          end
          chip8x_pkg::ALU_SUB: begin
            result_o.flag_written = 1'b1;
            result_o.flag_value   = (vx_i >= vy_i);
            result_o.reg_value    = vx_i - vy_i;
          end
          chip8x_pkg::ALU_SHR: begin
            result_o.flag_written = 1'b1;
            result_o.flag_value   = vx_i[0];
            result_o.reg_value    = {1'b0, vx_i[chip8x_pkg::RegW-1:1]};
          end
          chip8x_pkg::ALU_SUBN: begin
            result_o.flag_written = 1'b1;
            result_o.flag_value   = (vy_i >= vx_i);
            result_o.reg_value    = vy_i - vx_i;
          end
          chip8x_pkg::ALU_SHL: begin
            result_o.flag_written = 1'b1;
            result_o.flag_value   = vx_i[chip8x_pkg::RegW-1];
            result_o.reg_value    = {vx_i[chip8x_pkg::RegW-2:0], 1'b0};
          end
          default: begin
            // Undecoded register operation: no write at all.
            result_o.reg_written = 1'b0;
            result_o.reg_number  = '0;
            result_o.unsupported = 1'b1;
          end
        endcase
      end
      chip8x_pkg::GRP_SNE_REG: begin
        if (n == 4'h0) begin
          is_skip = 1'b1;
          cond    = (vx_i != vy_i);
        end else begin
          result_o.unsupported = 1'b1;
        end
      end
      chip8x_pkg::GRP_LD_I: begin
        result_o.index_value = nnn;
      end
      chip8x_pkg::GRP_JP_V0: begin
        result_o.next_pc = nnn + {4'b0000, v0_i};
      end
      chip8x_pkg::GRP_RND: begin
        result_o.reg_written = 1'b1;
        result_o.reg_number  = x;
        result_o.reg_value   = random_byte_i & kk;
      end
      chip8x_pkg::GRP_KEY: begin
        if (kk == chip8x_pkg::KkSkp) begin
          is_skip = 1'b1;
          cond    = key_down;
        end else if (kk == chip8x_pkg::KkSknp) begin
          is_skip = 1'b1;
          cond    = !key_down;
        end else begin
          result_o.unsupported = 1'b1;
        end
      end
      default: begin
        // Draw and the F group are not handled here.
        result_o.unsupported = 1'b1;
      end
    endcase

    if (is_skip && cond) begin
      result_o.skipped = 1'b1;
      result_o.next_pc = pc_plus4;
    end
  end

endmodule

>>> rtl/core/chip8_instruction_execute_core.sv
// Instruction execute core for a CHIP-8 machine.
// Input stream (s_axis): one transaction carries one fetched instruction together with
// the keypad bitmap and a random byte. Output stream (m_axis): one transaction per
// instruction with the new pc, the index register, the register and flag writes and
// status bits (screen clear, skip taken, stack fault, unsupported opcode).
// Configuration channel (cfg): writes the entry address, which also loads the pc.
// Write it only while no instruction is in flight.
// The result of an instruction is registered in the output register as it leaves the
// input register, which it does once the output register is free or being taken.
// Throughput: one instruction per cycle while the receiver keeps up. Each instruction
// reads and updates the register file, index register, pc and return stack in the
// execute step between the input register and the result register, so the next
// instruction sees all of its effects.
// Reset clears the general registers, the index register and the stack level and
// loads the pc with 0x200. When the receiver stalls, the result stays in the output
// register and one more instruction can wait in the input register; then s_axis_tready
// drops until the receiver takes the result.
module chip8_instruction_execute_core #(
  parameter int unsigned STACK_DEPTH = chip8x_pkg::StackDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [chip8x_pkg::AddrW-1:0] cfg_data_i,      // entry_address
  // Instruction stream.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [39:0]                  s_axis_tdata,    // opcode, key_states, random_byte
  // Result stream.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // next_pc, index_value, reg_written, reg_number, reg_value, flag_written,
  // flag_value, clear_screen, skipped, stack_fault, unsupported
  output logic [47:0]                  m_axis_tdata
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned NumRegs = 2 ** chip8x_pkg::RegNumW;
  localparam logic [chip8x_pkg::RegNumW-1:0] RegV0 = '0;
  localparam logic [chip8x_pkg::RegNumW-1:0] RegVf = '1;

  // Handshake and pipeline control.
  logic in_valid_q;
  logic out_valid_q;
  logic s_accept;
  logic advance;

  // Input register.
  logic [15:0] opcode_q;
  logic [15:0] keys_q;
  logic [7:0]  rnd_q;

  // Architectural state.
  logic [chip8x_pkg::AddrW-1:0]  pc_q;
  logic [chip8x_pkg::AddrW-1:0]  index_q;
  logic [chip8x_pkg::RegW-1:0]   v0_q;
  logic [chip8x_pkg::RegW-1:0]   vf_q;
  logic [NumRegs-1:0]            reg_valid_q;
  logic [chip8x_pkg::RegW-1:0]   reg_mem [NumRegs];
  logic [chip8x_pkg::RegW-1:0]   rx_q;
  logic [chip8x_pkg::RegW-1:0]   ry_q;
  logic [LW-1:0]                 level_q;
  logic [LW-1:0]                 level_d;
  logic [chip8x_pkg::AddrW-1:0]  stack_mem [STACK_DEPTH];
  logic [chip8x_pkg::AddrW-1:0]  top_q;
  logic [AW-1:0]                 top_addr;
  logic [LW-1:0]                 level_m1;

  // Execute signals.
  logic [3:0]                    x_in;
  logic [3:0]                    y_in;
  logic [3:0]                    x_q;
  logic [3:0]                    y_q;
  logic [chip8x_pkg::RegW-1:0]   vx;
  logic [chip8x_pkg::RegW-1:0]   vy;
  logic                          wr_en;
  chip8x_pkg::result_t           res;
  chip8x_pkg::stack_ctrl_t       sctl;
  chip8x_pkg::result_t           out_q;

  assign cfg_ready_o   = 1'b1;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;

  assign x_in = s_axis_tdata[11:8];
  assign y_in = s_axis_tdata[7:4];
  assign x_q  = opcode_q[11:8];
  assign y_q  = opcode_q[7:4];

  // V0 and VF live in their own registers; the others come from the file read.
  always_comb begin
    if (x_q == RegV0) begin
      vx = v0_q;
    end else if (x_q == RegVf) begin
      vx = vf_q;
    end else begin
      vx = rx_q;
    end
    if (y_q == RegV0) begin
      vy = v0_q;
    end else if (y_q == RegVf) begin
      vy = vf_q;
    end else begin
      vy = ry_q;
    end
  end

  chip8x_exec u_exec (
    .opcode_i      (opcode_q),
    .key_states_i  (keys_q),
    .random_byte_i (rnd_q),
    .vx_i          (vx),
    .vy_i          (vy),
    .v0_i          (v0_q),
    .pc_i          (pc_q),
    .index_i       (index_q),
    .stack_top_i   (top_q),
    .stack_empty_i (level_q == '0),
    .stack_full_i  (level_q == LW'(STACK_DEPTH)),
    .result_o      (res),
    .stack_ctrl_o  (sctl)
  );

  assign wr_en = advance && res.reg_written;

  // Pipeline valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      opcode_q <= s_axis_tdata[15:0];
      keys_q   <= s_axis_tdata[31:16];
      rnd_q    <= s_axis_tdata[39:32];
    end
    if (advance) begin
      out_q <= res;
    end
  end

  // Pc, index, shadow registers and stack level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= chip8x_pkg::EntryReset;
      index_q     <= '0;
      v0_q        <= '0;
      vf_q        <= '0;
      reg_valid_q <= '0;
      level_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        pc_q <= cfg_data_i;
      end else if (advance) begin
        pc_q <= res.next_pc;
      end
      if (advance) begin
        index_q <= res.index_value;
        level_q <= level_d;
      end
      if (wr_en) begin
        reg_valid_q[res.reg_number] <= 1'b1;
      end
      if (wr_en && res.reg_number == RegV0) begin
        v0_q <= res.reg_value;
      end
      // The result write to VF takes priority over the flag write.
      if (wr_en && res.reg_number == RegVf) begin
        vf_q <= res.reg_value;
      end else if (advance && res.flag_written) begin
        vf_q <= {{(chip8x_pkg::RegW-1){1'b0}}, res.flag_value};
      end
    end
  end

  // Register file: one write, two reads taken when an instruction enters,
  // with the write of the instruction executing in that cycle passed through.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      reg_mem[res.reg_number] <= res.reg_value;
    end
    if (s_accept) begin
      if (wr_en && res.reg_number == x_in) begin
        rx_q <= res.reg_value;
      end else if (reg_valid_q[x_in]) begin
        rx_q <= reg_mem[x_in];
      end else begin
        rx_q <= '0;
      end
      if (wr_en && res.reg_number == y_in) begin
        ry_q <= res.reg_value;
      end else if (reg_valid_q[y_in]) begin
        ry_q <= reg_mem[y_in];
      end else begin
        ry_q <= '0;
      end
    end
  end

  // Next stack level.
  always_comb begin
    level_d = level_q;
    if (advance && sctl.push) begin
      level_d = level_q + LW'(1);
    end else if (advance && sctl.pop) begin
      level_d = level_q - LW'(1);
    end
  end

  assign level_m1 = level_d - LW'(1);
  assign top_addr = (level_d == '0) ? '0 : level_m1[AW-1:0];

  // Return stack: top_q always holds the entry just below the level.
  always_ff @(posedge clk_i) begin
    if (advance && sctl.push) begin
      stack_mem[level_q[AW-1:0]] <= pc_q;
    end
    if (advance && sctl.push) begin
      top_q <= pc_q;
    end else begin
      top_q <= stack_mem[top_addr];
    end
  end

  // Result packing, first field in the lowest bits.
  assign m_axis_tdata = {5'b00000,
                         out_q.unsupported,
                         out_q.stack_fault,
                         out_q.skipped,
                         out_q.clear_screen,
                         out_q.flag_value,
                         out_q.flag_written,
                         out_q.reg_value,
                         out_q.reg_number,
                         out_q.reg_written,
                         out_q.index_value,
                         out_q.next_pc};

`ifndef NO_ASSERTIONS
  // The stack level never passes the stack depth.
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LW'(STACK_DEPTH))
    else $error("stack level beyond depth");

  // A stack fault leaves the stack level as it was.
  a_fault_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.stack_fault |=> $stable(level_q))
    else $error("stack level changed on a stack fault");

  // An unsupported opcode writes no register and no flag.
  a_unsup_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.unsupported |-> !res.reg_written && !res.flag_written)
    else $error("unsupported opcode wrote a register");

  // A write to V0 reaches its shadow register.
  a_v0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && res.reg_number == RegV0 |=> v0_q == $past(res.reg_value))
    else $error("V0 shadow not updated");
`endif

endmodule
